FILE: rtl/sync_length_sum_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser checker
// Shared concurrent property wrappers used by the bound checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define SLSFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SLSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/slsfp_pkg.sv
// ----------------------------------------------------------------------------
// slsfp_pkg
// Shared constants, controller state encoding and control/status bundles
// for the sync/length/sum frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slsfp_pkg;

   // Default payload capacity
   localparam int MAX_PAYLOAD_DEF = 32;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int PLEN_W  = 6;
   localparam int INDEX_W = 5;

   // Reset value of the sync marker register
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd170;

   // Controller states, one-hot
   typedef enum logic [6:0] {
      ST_WAIT      = 7'b0000001,
      ST_CMD       = 7'b0000010,
      ST_LEN       = 7'b0000100,
      ST_DATA      = 7'b0001000,
      ST_CHECK     = 7'b0010000,
      ST_EMIT_READ = 7'b0100000,
      ST_EMIT_SEND = 7'b1000000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic begin_frame;
      logic take_cmd;
      logic take_len;
      logic take_data;
      logic start_run;
      logic emit_read;
      logic emit_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic rx_is_sync;
      logic len_too_big;
      logic len_zero;
      logic fill_done;
      logic sum_match;
      logic run_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/slsfp_ctrl.sv
// ----------------------------------------------------------------------------
// slsfp_ctrl
// Frame parser controller: walks sync, command, length, payload and check
// phases, then sequences the result run out of the payload store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slsfp_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  slsfp_pkg::status_type    sts,
   output slsfp_pkg::cmd_type       cmd
);

   slsfp_pkg::state_type state_ff;
   slsfp_pkg::state_type state_in;
   logic                 in_fire;

   // Hold off input while the result run is going out
   assign req_stall = (state_ff == slsfp_pkg::ST_EMIT_READ) ||
                      (state_ff == slsfp_pkg::ST_EMIT_SEND);
   assign in_fire   = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         slsfp_pkg::ST_WAIT: begin
            if (in_fire && sts.rx_is_sync) begin
               cmd.begin_frame = 1'b1;
               state_in        = slsfp_pkg::ST_CMD;
            end
         end
         slsfp_pkg::ST_CMD: begin
            if (in_fire) begin
               cmd.take_cmd = 1'b1;
               state_in     = slsfp_pkg::ST_LEN;
            end
         end
         slsfp_pkg::ST_LEN: begin
            if (in_fire) begin
               if (sts.len_too_big) begin
                  state_in = slsfp_pkg::ST_WAIT;
               end else begin
                  cmd.take_len = 1'b1;
                  state_in     = sts.len_zero ? slsfp_pkg::ST_CHECK : slsfp_pkg::ST_DATA;
               end
            end
         end
         slsfp_pkg::ST_DATA: begin
            if (in_fire) begin
               cmd.take_data = 1'b1;
               if (sts.fill_done) begin
                  state_in = slsfp_pkg::ST_CHECK;
               end
            end
         end
         slsfp_pkg::ST_CHECK: begin
            if (in_fire) begin
               if (sts.sum_match) begin
                  cmd.start_run = 1'b1;
                  state_in      = slsfp_pkg::ST_EMIT_READ;
               end else if (sts.rx_is_sync) begin
                  cmd.begin_frame = 1'b1;
                  state_in        = slsfp_pkg::ST_CMD;
               end else begin
                  state_in = slsfp_pkg::ST_WAIT;
               end
            end
         end
         slsfp_pkg::ST_EMIT_READ: begin
            cmd.emit_read = 1'b1;
            state_in      = slsfp_pkg::ST_EMIT_SEND;
         end
         slsfp_pkg::ST_EMIT_SEND: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = sts.run_last ? slsfp_pkg::ST_WAIT : slsfp_pkg::ST_EMIT_READ;
            end
         end
         default: begin
            state_in = slsfp_pkg::ST_WAIT;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slsfp_pkg::ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/slsfp_datapath.sv
// ----------------------------------------------------------------------------
// slsfp_datapath
// Frame parser datapath: sync register, frame header registers, running
// sum, payload store and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slsfp_datapath #(
   parameter int MAX_PAYLOAD = slsfp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [slsfp_pkg::BYTE_W-1:0]        csr_write_data,
   input  wire  [slsfp_pkg::BYTE_W-1:0]        req_rx_byte,
   input  slsfp_pkg::cmd_type                  cmd,
   output slsfp_pkg::status_type               sts,
   input  wire                                 rsp_stall,
   output logic                                rsp_valid,
   output logic [slsfp_pkg::BYTE_W-1:0]        rsp_command,
   output logic [slsfp_pkg::PLEN_W-1:0]        rsp_frame_length,
   output logic                                rsp_has_payload,
   output logic [slsfp_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [slsfp_pkg::INDEX_W-1:0]       rsp_byte_index,
   output logic                                rsp_last
);

   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [slsfp_pkg::BYTE_W-1:0]  sync_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  sum_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  command_ff;
   logic [LEN_W-1:0]              length_ff;
   logic [LEN_W-1:0]              fill_ff;
   logic [LEN_W-1:0]              rd_ptr_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  rd_data_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  payload_mem [MAX_PAYLOAD];

   logic                          out_valid_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  out_command_ff;
   logic [slsfp_pkg::PLEN_W-1:0]  out_length_ff;
   logic                          out_has_ff;
   logic [slsfp_pkg::BYTE_W-1:0]  out_data_ff;
   logic [slsfp_pkg::INDEX_W-1:0] out_index_ff;
   logic                          out_last_ff;

   logic [LEN_W:0]                fill_next;
   logic [LEN_W:0]                ptr_next;
   logic                          run_empty;
   logic [LEN_W+slsfp_pkg::INDEX_W-1:0] ptr_ext;
   logic [LEN_W+slsfp_pkg::PLEN_W-1:0]  len_ext;

   // Status toward the controller
   assign fill_next       = {1'b0, fill_ff} + 1'b1;
   assign ptr_next        = {1'b0, rd_ptr_ff} + 1'b1;
   assign run_empty       = (length_ff == '0);
   assign sts.rx_is_sync  = (req_rx_byte == sync_ff);
   assign sts.len_too_big = (req_rx_byte > slsfp_pkg::BYTE_W'(MAX_PAYLOAD));
   assign sts.len_zero    = (req_rx_byte == '0);
   assign sts.fill_done   = (fill_next >= {1'b0, length_ff});
   assign sts.sum_match   = (req_rx_byte == sum_ff);
   assign sts.run_last    = run_empty || (ptr_next == {1'b0, length_ff});
   assign sts.out_free    = !out_valid_ff || !rsp_stall;

   // Sync marker register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= slsfp_pkg::SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_ff <= csr_write_data;
      end
   end

   // Frame header, fill position and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         fill_ff    <= '0;
      end else begin
         if (cmd.begin_frame) begin
            sum_ff     <= sync_ff;
            command_ff <= '0;
            length_ff  <= '0;
            fill_ff    <= '0;
         end
         if (cmd.take_cmd) begin
            command_ff <= req_rx_byte;
            sum_ff     <= sum_ff + req_rx_byte;
         end
         if (cmd.take_len) begin
            length_ff <= req_rx_byte[LEN_W-1:0];
            fill_ff   <= '0;
            sum_ff    <= sum_ff + req_rx_byte;
         end
         if (cmd.take_data) begin
            fill_ff <= fill_next[LEN_W-1:0];
            sum_ff  <= sum_ff + req_rx_byte;
         end
      end
   end

   // Payload store: write while filling, registered read during the run
   always_ff @(posedge clock) begin
      if (cmd.take_data) begin
         payload_mem[fill_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (cmd.emit_read) begin
         rd_data_ff <= payload_mem[rd_ptr_ff[ADDR_W-1:0]];
      end
   end

   // Run read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
      end else if (cmd.start_run) begin
         rd_ptr_ff <= '0;
      end else if (cmd.emit_load) begin
         rd_ptr_ff <= ptr_next[LEN_W-1:0];
      end
   end

   // Fit run pointer and length into the result field widths
   assign ptr_ext = {{slsfp_pkg::INDEX_W{1'b0}}, rd_ptr_ff};
   assign len_ext = {{slsfp_pkg::PLEN_W{1'b0}}, length_ff};

   // Result output register: load a result, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_command_ff <= command_ff;
         out_length_ff  <= len_ext[slsfp_pkg::PLEN_W-1:0];
         out_has_ff     <= !run_empty;
         out_data_ff    <= run_empty ? '0 : rd_data_ff;
         out_index_ff   <= ptr_ext[slsfp_pkg::INDEX_W-1:0];
         out_last_ff    <= sts.run_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command        = out_command_ff;
   assign rsp_frame_length   = out_length_ff;
   assign rsp_has_payload    = out_has_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_byte_index     = out_index_ff;
   assign rsp_last           = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/sync_length_sum_frame_parser_unit.sv
// After the check byte transfer, a good frame's first result takes the store read state,
// then the output register load state, which waits while a stalled result is held.
// Throughput: one byte per cycle while parsing; a good frame then emits its run one result
// at a time, each a store read then an output load, input held; rsp_stall stretches it.
// Reset: synchronous, clears the controller, header registers, sum and output valid;
// the payload store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sync_length_sum_frame_parser_unit
// Frame parser for sync/command/length/payload/check streams with an 8-bit
// wrapping sum check; one result per payload byte of a good frame, one if it is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_length_sum_frame_parser_unit #(
   parameter int MAX_PAYLOAD = slsfp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [slsfp_pkg::BYTE_W-1:0]        csr_write_data,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [slsfp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [slsfp_pkg::BYTE_W-1:0]        rsp_command,
   output logic [slsfp_pkg::PLEN_W-1:0]        rsp_frame_length,
   output logic                                rsp_has_payload,
   output logic [slsfp_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [slsfp_pkg::INDEX_W-1:0]       rsp_byte_index,
   output logic                                rsp_last
);

   slsfp_pkg::cmd_type    cmd;
   slsfp_pkg::status_type sts;

   // Phase sequencing
   slsfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, sum and result register
   slsfp_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_command        (rsp_command),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

FILE: rtl/slsfp_checker.sv
// ----------------------------------------------------------------------------
// slsfp_checker
// Port-level checks on the frame parser result channel, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_length_sum_frame_parser_unit_assert.svh"

module slsfp_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [slsfp_pkg::BYTE_W-1:0]    rsp_command,
   input wire [slsfp_pkg::PLEN_W-1:0]    rsp_frame_length,
   input wire                            rsp_has_payload,
   input wire [slsfp_pkg::BYTE_W-1:0]    rsp_data_byte,
   input wire [slsfp_pkg::INDEX_W-1:0]   rsp_byte_index,
   input wire                            rsp_last
);

   // Hold a stalled result until it transfers
   `SLSFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data_byte) && $stable(rsp_byte_index) && $stable(rsp_command),
      "stalled result changed")

   // An empty frame gives one closing result with zeroed data
   `SLSFP_ASSERT_NOW(a_empty_last, clock, reset, rsp_valid && !rsp_has_payload,
      rsp_last && (rsp_data_byte == '0) && (rsp_byte_index == '0),
      "empty frame result malformed")

   // The closing payload result sits at the last position of the frame
   `SLSFP_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_has_payload && rsp_last,
      rsp_byte_index == slsfp_pkg::INDEX_W'(rsp_frame_length - 1'b1),
      "last result at wrong index")

   // A transferred non-final payload result is followed by the next position
   `SLSFP_ASSERT_NEXT(a_index_step, clock, reset,
      rsp_valid && !rsp_stall && rsp_has_payload && !rsp_last,
      !rsp_valid || (rsp_byte_index == $past(rsp_byte_index) + 1'b1),
      "run position skipped")

endmodule

bind sync_length_sum_frame_parser_unit slsfp_checker u_slsfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_command        (rsp_command),
   .rsp_frame_length   (rsp_frame_length),
   .rsp_has_payload    (rsp_has_payload),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_last           (rsp_last)
);

`default_nettype wire
